// ===== hdl/msac_pkg.sv =====
// ----------------------------------------------------------------------------
// msac_pkg
// Types and fixed constants shared by the square-activation classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package msac_pkg;

    // fixed field widths
    localparam int unsigned ACC_W       = 64;
    localparam int unsigned FEAT_W      = 8;
    localparam int unsigned THR_W       = 8;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 136;
    localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - (2 * ACC_W + 1);

    localparam logic [THR_W-1:0] THR_RESET = 8'd37;

    // tuser codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_FEAT = 1'b1;

    // load targets
    localparam logic [1:0] LYR_ONE   = 2'd0;
    localparam logic [1:0] LYR_TWO   = 2'd1;
    localparam logic [1:0] LYR_THREE = 2'd2;
    localparam logic [1:0] LYR_FOUR  = 2'd3;

    // result class codes
    localparam logic CLS_ZERO = 1'b0;
    localparam logic CLS_ONE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        STEP_ACC,
        STEP_SQ,
        STEP_L2,
        STEP_L3,
        STEP_L4
    } t_step;

endpackage

`default_nettype wire

// ===== hdl/mlp_square_activation_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// mlp_square_activation_classifier_unit
// Integer perceptron with square activation and a thresholded class output.
// ----------------------------------------------------------------------------
// a load item writes its weight store and leaves the unit idle; a feature item
// runs the accumulate pass over HIDDEN_ONE rows; a last feature adds the square
// pass and the three dense layers, one mac per cycle with a pipeline drain after
// each pass; a last feature whose position is out of range skips the accumulate
// pass; the result item holds until taken
// reset is synchronous, active low: control, threshold and sum valid bits clear,
// weight stores stay unknown until written
`default_nettype none

module mlp_square_activation_classifier_unit #(
    parameter int IN_DIM       = 4000,
    parameter int HIDDEN_ONE   = 40,
    parameter int HIDDEN_TWO   = 20,
    parameter int HIDDEN_THREE = 10,
    parameter int OUT_DIM      = 2,
    parameter int WEIGHT_BITS  = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [msac_pkg::THR_W-1:0]       i_cfg_wdata,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // layer_sel[1:0], row_index[7:2], col_index[19:8], weight_value[27:20],
    // feature_value[35:28], zero pad
    input  wire logic [msac_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // action
    input  wire logic                             i_s_axis_tuser,
    input  wire logic                             i_s_axis_tlast,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // class_out[0], logit_zero[64:1], logit_one[128:65], zero pad
    output logic [msac_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata
);
    import msac_pkg::*;

    localparam int W1_D = HIDDEN_ONE * IN_DIM;
    localparam int W2_D = HIDDEN_TWO * HIDDEN_ONE;
    localparam int W3_D = HIDDEN_THREE * HIDDEN_TWO;
    localparam int W4_D = OUT_DIM * HIDDEN_THREE;
    localparam int W1_A = (W1_D > 1) ? $clog2(W1_D) : 1;
    localparam int W2_A = (W2_D > 1) ? $clog2(W2_D) : 1;
    localparam int W3_A = (W3_D > 1) ? $clog2(W3_D) : 1;
    localparam int W4_A = (W4_D > 1) ? $clog2(W4_D) : 1;
    localparam int FL_T = (W2_A > W3_A) ? W2_A : W3_A;
    localparam int FL_A = (FL_T > W4_A) ? FL_T : W4_A;
    localparam int A_D  = (HIDDEN_ONE > HIDDEN_THREE) ? HIDDEN_ONE : HIDDEN_THREE;
    localparam int A_A  = (A_D > 1) ? $clog2(A_D) : 1;
    localparam int B_D  = HIDDEN_TWO;
    localparam int B_A  = (B_D > 1) ? $clog2(B_D) : 1;
    localparam int D_T  = (HIDDEN_ONE > HIDDEN_TWO) ? HIDDEN_ONE : HIDDEN_TWO;
    localparam int D_M  = (D_T > HIDDEN_THREE) ? D_T : HIDDEN_THREE;
    localparam int CNT_W = $clog2(D_M + 1);
    localparam int WB   = WEIGHT_BITS;

    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic   r_last;
    logic [FEAT_W-1:0]       r_feat;
    logic [THR_W-1:0]        r_thr;
    logic [CNT_W-1:0]        r_row, r_col;
    logic [W1_A-1:0]         r_w1_addr;
    logic [FL_A-1:0]         r_flat;

    logic [WB-1:0] mem_w1 [W1_D];
    logic [WB-1:0] mem_w2 [W2_D];
    logic [WB-1:0] mem_w3 [W3_D];
    logic [WB-1:0] mem_w4 [W4_D];
    logic [WB-1:0] r_w1_q, r_w2_q, r_w3_q, r_w4_q;
    logic [ACC_W-1:0] mem_a [A_D];
    logic [ACC_W-1:0] mem_b [B_D];
    logic [ACC_W-1:0] r_a_q, r_b_q;
    logic [A_D-1:0]   r_a_vld;
    logic             r_a_vq;

    logic             r_p1_vld, r_p1_first, r_p1_lastc;
    logic [CNT_W-1:0] r_p1_row;
    logic             r_p2_vld, r_p2_first, r_p2_lastc;
    logic [CNT_W-1:0] r_p2_row;
    logic [ACC_W-1:0] r_prod, r_sum, r_sq_p0, r_acc, r_lo0, r_lo1;
    logic [31:0]      r_sq_p1;

    // input decode
    logic [1:0]        in_layer;
    logic [5:0]        in_row;
    logic [11:0]       in_col;
    logic [7:0]        in_wv;
    logic [FEAT_W-1:0] in_feat;
    logic              in_acc, ld_en, feat_en, col_ok;
    logic [WB-1:0]     wv_st;
    logic [15:0]       wv_16;

    assign in_layer = i_s_axis_tdata[1:0];
    assign in_row   = i_s_axis_tdata[7:2];
    assign in_col   = i_s_axis_tdata[19:8];
    assign in_wv    = i_s_axis_tdata[27:20];
    assign in_feat  = i_s_axis_tdata[35:28];
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign ld_en    = in_acc && (i_s_axis_tuser == ACT_LOAD);
    assign feat_en  = in_acc && (i_s_axis_tuser == ACT_FEAT);
    assign col_ok   = 32'(in_col) < IN_DIM;
    assign wv_16    = {{8{in_wv[7]}}, in_wv};
    assign wv_st    = wv_16[WB-1:0];

    logic we1, we2, we3, we4;
    assign we1 = ld_en && (in_layer == LYR_ONE) && (32'(in_row) < HIDDEN_ONE) && col_ok;
    assign we2 = ld_en && (in_layer == LYR_TWO) && (32'(in_row) < HIDDEN_TWO)
                 && (32'(in_col) < HIDDEN_ONE);
    assign we3 = ld_en && (in_layer == LYR_THREE) && (32'(in_row) < HIDDEN_THREE)
                 && (32'(in_col) < HIDDEN_TWO);
    assign we4 = ld_en && (in_layer == LYR_FOUR) && (32'(in_row) < OUT_DIM)
                 && (32'(in_col) < HIDDEN_THREE);

    logic [W1_A-1:0] wa1;
    logic [W2_A-1:0] wa2;
    logic [W3_A-1:0] wa3;
    logic [W4_A-1:0] wa4;
    assign wa1 = W1_A'(in_row) * W1_A'(IN_DIM) + W1_A'(in_col);
    assign wa2 = W2_A'(in_row) * W2_A'(HIDDEN_ONE) + W2_A'(in_col);
    assign wa3 = W3_A'(in_row) * W3_A'(HIDDEN_TWO) + W3_A'(in_col);
    assign wa4 = W4_A'(in_row) * W4_A'(HIDDEN_THREE) + W4_A'(in_col);

    // sequencer extents
    logic [CNT_W-1:0] rows_last, cols_last;
    logic issue, col_end, row_end, run_done, pipe_empty;

    always_comb begin
        case (r_step)
            STEP_L2: begin
                rows_last = CNT_W'(HIDDEN_TWO - 1);
                cols_last = CNT_W'(HIDDEN_ONE - 1);
            end
            STEP_L3: begin
                rows_last = CNT_W'(HIDDEN_THREE - 1);
                cols_last = CNT_W'(HIDDEN_TWO - 1);
            end
            STEP_L4: begin
                rows_last = CNT_W'(OUT_DIM - 1);
                cols_last = CNT_W'(HIDDEN_THREE - 1);
            end
            default: begin
                rows_last = CNT_W'(HIDDEN_ONE - 1);
                cols_last = '0;
            end
        endcase
    end

    assign col_end    = r_col == cols_last;
    assign row_end    = r_row == rows_last;
    assign run_done   = issue && col_end && row_end;
    assign pipe_empty = !r_p1_vld && !r_p2_vld;

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (feat_en) begin
                    if (col_ok) begin
                        n_state = ST_RUN;
                        n_step  = STEP_ACC;
                    end else if (i_s_axis_tlast) begin
                        n_state = ST_RUN;
                        n_step  = STEP_SQ;
                    end
                end
            end
            ST_RUN: begin
                if (run_done) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    n_state = ST_RUN;
                    case (r_step)
                        STEP_ACC: begin
                            if (r_last) begin
                                n_step = STEP_SQ;
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end
                        STEP_SQ: n_step = STEP_L2;
                        STEP_L2: n_step = STEP_L3;
                        STEP_L3: n_step = STEP_L4;
                        default: n_state = ST_OUT;
                    endcase
                end
            end
            ST_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        issue           = 1'b0;
        case (r_state)
            ST_IDLE: o_s_axis_tready = 1'b1;
            ST_RUN:  issue = 1'b1;
            ST_OUT:  o_m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_ACC;
            r_thr   <= THR_RESET;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    // counters and item fields
    always_ff @(posedge i_clk) begin
        if (feat_en) begin
            r_feat    <= in_feat;
            r_last    <= i_s_axis_tlast;
            r_row     <= '0;
            r_col     <= '0;
            r_flat    <= '0;
            r_w1_addr <= W1_A'(in_col);
        end else if (run_done) begin
            r_row  <= '0;
            r_col  <= '0;
            r_flat <= '0;
        end else if (issue) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
            r_flat    <= r_flat + 1'b1;
            r_w1_addr <= r_w1_addr + W1_A'(IN_DIM);
        end
    end

    // weight stores
    always_ff @(posedge i_clk) begin
        if (we1) begin
            mem_w1[wa1] <= wv_st;
        end
        r_w1_q <= mem_w1[r_w1_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we2) begin
            mem_w2[wa2] <= wv_st;
        end
        r_w2_q <= mem_w2[r_flat[W2_A-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (we3) begin
            mem_w3[wa3] <= wv_st;
        end
        r_w3_q <= mem_w3[r_flat[W3_A-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (we4) begin
            mem_w4[wa4] <= wv_st;
        end
        r_w4_q <= mem_w4[r_flat[W4_A-1:0]];
    end

    // activation stores
    logic [A_A-1:0]   a_rd_addr, a_wr_addr;
    logic [B_A-1:0]   b_wr_addr;
    logic             a_we, b_we;
    logic [ACC_W-1:0] a_wd;
    logic [ACC_W-1:0] n_acc;

    assign a_rd_addr = ((r_step == STEP_ACC) || (r_step == STEP_SQ)) ? r_row[A_A-1:0]
                                                                     : r_col[A_A-1:0];
    assign a_wr_addr = r_p2_row[A_A-1:0];
    assign b_wr_addr = r_p2_row[B_A-1:0];

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            mem_a[a_wr_addr] <= a_wd;
        end
        r_a_q <= mem_a[a_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            mem_b[b_wr_addr] <= n_acc;
        end
        r_b_q <= mem_b[r_col[B_A-1:0]];
    end

    // sums read as zero until written since the last result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= '0;
            r_a_vq  <= 1'b0;
        end else begin
            r_a_vq <= r_a_vld[a_rd_addr];
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_a_vld <= '0;
            end else if (a_we) begin
                r_a_vld[a_wr_addr] <= 1'b1;
            end
        end
    end

    // read stage: operand select and the shared multiply
    logic [ACC_W-1:0] a_val, x_op, prod_u, prod, sq_p0;
    logic [WB-1:0]    w_op;
    logic [31:0]      sq_lo, sq_hi, sq_p1;

    assign a_val = r_a_vq ? r_a_q : '0;

    always_comb begin
        case (r_step)
            STEP_ACC: begin
                x_op = ACC_W'(r_feat);
                w_op = r_w1_q;
            end
            STEP_L2: begin
                x_op = a_val;
                w_op = r_w2_q;
            end
            STEP_L3: begin
                x_op = r_b_q;
                w_op = r_w3_q;
            end
            default: begin
                x_op = a_val;
                w_op = r_w4_q;
            end
        endcase
    end

    // signed weight: unsigned product less x shifted by the weight width
    assign prod_u = x_op * w_op;
    assign prod   = prod_u - (w_op[WB-1] ? (x_op << WB) : '0);
    assign sq_lo  = a_val[31:0];
    assign sq_hi  = a_val[63:32];
    assign sq_p0  = sq_lo * sq_lo;
    assign sq_p1  = sq_lo * sq_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= issue;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_row   <= r_row;
        r_p1_first <= r_col == '0;
        r_p1_lastc <= col_end;
        r_p2_row   <= r_p1_row;
        r_p2_first <= r_p1_first;
        r_p2_lastc <= r_p1_lastc;
        r_prod     <= prod;
        r_sum      <= a_val;
        r_sq_p0    <= sq_p0;
        r_sq_p1    <= sq_p1;
    end

    // accumulate stage
    logic [ACC_W-1:0] sq_val;
    logic             lo_we;

    assign n_acc  = (r_p2_first ? '0 : r_acc) + r_prod;
    // cross term of the square lands at bit 33
    assign sq_val = r_sq_p0 + {r_sq_p1[30:0], 33'b0};

    always_comb begin
        a_we  = 1'b0;
        b_we  = 1'b0;
        lo_we = 1'b0;
        a_wd  = n_acc;
        if (r_p2_vld) begin
            case (r_step)
                STEP_ACC: begin
                    a_we = 1'b1;
                    a_wd = r_sum + r_prod;
                end
                STEP_SQ: begin
                    a_we = 1'b1;
                    a_wd = sq_val;
                end
                STEP_L2: b_we = r_p2_lastc;
                STEP_L3: a_we = r_p2_lastc;
                default: lo_we = r_p2_lastc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p2_vld) begin
            r_acc <= n_acc;
        end
        if (lo_we) begin
            if (r_p2_row == '0) begin
                r_lo0 <= n_acc;
            end else begin
                r_lo1 <= n_acc;
            end
        end
    end

    // result
    logic [ACC_W-1:0] thr_ext;
    logic             cls;

    assign thr_ext = {{(ACC_W-THR_W){r_thr[THR_W-1]}}, r_thr};
    assign cls     = ($signed(r_lo0) >= $signed(thr_ext)) ? CLS_ZERO : CLS_ONE;
    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, r_lo1, r_lo0, cls};

endmodule

`default_nettype wire

// ===== hdl/msac_checker.sv =====
// ----------------------------------------------------------------------------
// msac_checker
// Port-level checks on the classifier handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module msac_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_axis_tvalid,
    input wire logic                             o_s_axis_tready,
    input wire logic                             i_s_axis_tuser,
    input wire logic                             i_s_axis_tlast,
    input wire logic                             o_m_axis_tvalid,
    input wire logic                             i_m_axis_tready,
    input wire logic [msac_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import msac_pkg::*;

    // no item is taken while a result waits
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input ready while result pending");

    // a last feature item always starts the layer passes
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == ACT_FEAT)
         && i_s_axis_tlast) |=> !o_s_axis_tready)
        else $error("ready after last feature item");

    // one result per last feature
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready) |=> !o_m_axis_tvalid)
        else $error("result repeated");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind mlp_square_activation_classifier_unit msac_checker u_msac_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
